### src/owbm_pkg.sv
package owbm_pkg;

    localparam int unsigned NUM_REGS  = 8;
    localparam int unsigned REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_RESET_LOW       = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PRESENCE_SAMPLE = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RESET_RECOVER   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_WRITE_ONE_LOW   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WRITE_ZERO_LOW  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_READ_LOW        = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_READ_SAMPLE     = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SLOT            = 3'd7;

    localparam int unsigned REG_RESET_VALS [NUM_REGS] = '{480, 80, 400, 6, 50, 2, 2, 65};

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_RESET = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;
    localparam logic [1:0] FUNC_READ  = 2'd3;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_RLOW  = 3'd1;
    localparam logic [2:0] PH_RREL  = 3'd2;
    localparam logic [2:0] PH_WRITE = 3'd3;
    localparam logic [2:0] PH_READ  = 3'd4;

    localparam logic [2:0] LAST_BIT = 3'd7;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data_byte;
        logic       bus_level;
    } cmd_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] read_data;
        logic       rejected;
    } result_t;

endpackage

### src/owbm_if.sv
interface owbm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] data_byte;
    logic       bus_level;

    modport source (output valid, output func, output data_byte, output bus_level, input ready);
    modport sink (input valid, input func, input data_byte, input bus_level, output ready);
endinterface

interface owbm_out_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;
    logic       rejected;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output presence, output read_data, output rejected, input ready);
    modport sink (input valid, input drive_low, input busy_res, input done_res,
                  input presence, input read_data, input rejected, output ready);
endinterface

### src/owbm_cfg.sv
module owbm_cfg #(
    parameter int unsigned TIMER_BITS = 10
) (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  logic                                               we,
    input  logic [owbm_pkg::REG_IDX_W-1:0]                     addr,
    input  logic [TIMER_BITS-1:0]                              data,
    output logic [owbm_pkg::NUM_REGS-1:0][TIMER_BITS-1:0]      regs
);

    logic [owbm_pkg::NUM_REGS-1:0][TIMER_BITS-1:0] regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < owbm_pkg::NUM_REGS; i++)
            begin
                regs_reg[i] <= TIMER_BITS'(owbm_pkg::REG_RESET_VALS[i]);
            end
        end
        else if (we)
        begin
            regs_reg[addr] <= data;
        end
    end

    assign regs = regs_reg;

endmodule

### src/owbm_seq.sv
module owbm_seq #(
    parameter int unsigned TIMER_BITS = 10
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           step,
    input  owbm_pkg::cmd_t                                 cmd,
    input  logic [owbm_pkg::NUM_REGS-1:0][TIMER_BITS-1:0]  cfg,
    output owbm_pkg::result_t                              res
);

    localparam logic [TIMER_BITS-1:0] ONE = TIMER_BITS'(1);

    function automatic logic [TIMER_BITS-1:0] at_least_one(input logic [TIMER_BITS-1:0] v);
        return (v == '0) ? ONE : v;
    endfunction

    function automatic logic [TIMER_BITS-1:0] last_of(input logic [TIMER_BITS-1:0] v);
        return (v == '0) ? '0 : v - ONE;
    endfunction

    logic [2:0]            phase_reg, phase_next;
    logic [TIMER_BITS-1:0] tick_reg, tick_next;
    logic [2:0]            bit_reg, bit_next;
    logic [7:0]            shift_reg, shift_next;
    logic                  pres_reg, pres_next;
    logic [7:0]            rdata_reg, rdata_next;

    logic [2:0]            eff_phase;
    logic [TIMER_BITS-1:0] t;
    logic [7:0]            sb;
    logic [2:0]            bi;
    logic                  pres;
    logic                  rej;
    logic                  drive;
    logic                  done;
    logic                  end_slot;

    logic [TIMER_BITS-1:0] rlow_last;
    logic [TIMER_BITS-1:0] rel_last;
    logic [TIMER_BITS-1:0] slot_last;
    logic [TIMER_BITS-1:0] pres_sp;
    logic [TIMER_BITS-1:0] read_sp;
    logic [TIMER_BITS-1:0] write_low;
    logic [TIMER_BITS-1:0] read_low;

    assign rlow_last = last_of(cfg[owbm_pkg::REG_RESET_LOW]);
    assign rel_last  = last_of(cfg[owbm_pkg::REG_RESET_RECOVER]);
    assign slot_last = last_of(cfg[owbm_pkg::REG_SLOT]);
    assign pres_sp   = (cfg[owbm_pkg::REG_PRESENCE_SAMPLE] < rel_last)
                       ? cfg[owbm_pkg::REG_PRESENCE_SAMPLE] : rel_last;
    assign read_sp   = (cfg[owbm_pkg::REG_READ_SAMPLE] < slot_last)
                       ? cfg[owbm_pkg::REG_READ_SAMPLE] : slot_last;
    assign write_low = at_least_one(cfg[owbm_pkg::REG_WRITE_ONE_LOW]);
    assign read_low  = at_least_one(cfg[owbm_pkg::REG_READ_LOW]);

    always_comb
    begin
        eff_phase = phase_reg;
        t         = tick_reg;
        sb        = shift_reg;
        bi        = bit_reg;
        pres      = pres_reg;
        rej       = 1'b0;

        // a command item is also the first tick of its sequence
        if (phase_reg == owbm_pkg::PH_IDLE)
        begin
            case (cmd.func)
                owbm_pkg::FUNC_RESET:
                begin
                    eff_phase = owbm_pkg::PH_RLOW;
                    pres      = 1'b0;
                end
                owbm_pkg::FUNC_WRITE:
                begin
                    eff_phase = owbm_pkg::PH_WRITE;
                    bi        = '0;
                    sb        = cmd.data_byte;
                end
                owbm_pkg::FUNC_READ:
                begin
                    eff_phase = owbm_pkg::PH_READ;
                    bi        = '0;
                    sb        = '0;
                end
                default:
                begin
                    eff_phase = owbm_pkg::PH_IDLE;
                end
            endcase
            t = '0;
        end
        else if (cmd.func != owbm_pkg::FUNC_TICK)
        begin
            rej = 1'b1;
        end

        phase_next = eff_phase;
        bit_next   = bi;
        shift_next = sb;
        pres_next  = pres;
        rdata_next = rdata_reg;
        drive      = 1'b0;
        done       = 1'b0;
        end_slot   = 1'b0;

        case (eff_phase)
            owbm_pkg::PH_RLOW:
            begin
                drive = 1'b1;
                if (t >= rlow_last)
                begin
                    phase_next = owbm_pkg::PH_RREL;
                    end_slot   = 1'b1;
                end
            end
            owbm_pkg::PH_RREL:
            begin
                if (t == pres_sp)
                begin
                    pres_next = ~cmd.bus_level;
                end
                if (t >= rel_last)
                begin
                    phase_next = owbm_pkg::PH_IDLE;
                    done       = 1'b1;
                    end_slot   = 1'b1;
                end
            end
            owbm_pkg::PH_WRITE:
            begin
                drive = sb[0] ? (t < write_low)
                              : (t < at_least_one(cfg[owbm_pkg::REG_WRITE_ZERO_LOW]));
                if (t >= slot_last)
                begin
                    shift_next = {1'b0, sb[7:1]};
                    if (bi == owbm_pkg::LAST_BIT)
                    begin
                        phase_next = owbm_pkg::PH_IDLE;
                        done       = 1'b1;
                    end
                    else
                    begin
                        bit_next = bi + 3'd1;
                    end
                    end_slot = 1'b1;
                end
            end
            owbm_pkg::PH_READ:
            begin
                drive = (t < read_low);
                if (t == read_sp)
                begin
                    shift_next = {cmd.bus_level, sb[7:1]};
                end
                if (t >= slot_last)
                begin
                    if (bi == owbm_pkg::LAST_BIT)
                    begin
                        rdata_next = shift_next;
                        phase_next = owbm_pkg::PH_IDLE;
                        done       = 1'b1;
                    end
                    else
                    begin
                        bit_next = bi + 3'd1;
                    end
                    end_slot = 1'b1;
                end
            end
            default:
            begin
                phase_next = owbm_pkg::PH_IDLE;
            end
        endcase

        if (phase_next == owbm_pkg::PH_IDLE || end_slot)
        begin
            tick_next = '0;
        end
        else
        begin
            tick_next = t + ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= owbm_pkg::PH_IDLE;
            tick_reg  <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
            pres_reg  <= 1'b0;
            rdata_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            pres_reg  <= pres_next;
            rdata_reg <= rdata_next;
        end
    end

    always_comb
    begin
        res.drive_low = drive;
        res.busy_res  = (phase_next != owbm_pkg::PH_IDLE);
        res.done_res  = done;
        res.presence  = pres_next;
        res.read_data = rdata_next;
        res.rejected  = rej;
    end

    a_idle_tick_zero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == owbm_pkg::PH_IDLE |-> tick_reg == '0)
        else $error("tick counter running while idle");

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.done_res |=> phase_reg == owbm_pkg::PH_IDLE)
        else $error("sequence completed but phase not idle");

    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.rejected |-> phase_reg != owbm_pkg::PH_IDLE)
        else $error("command rejected while idle");

    a_release_no_drive: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == owbm_pkg::PH_RREL |-> !res.drive_low)
        else $error("bus driven during presence window");

endmodule

### src/one_wire_bus_master.sv
// one_wire_bus_master: single-pin 1-Wire bus master advanced by tick items
// cmd channel: one item per bus tick; func selects tick, reset/presence,
// byte write or byte read; a command item is the first tick of its sequence
// and is taken only when idle, otherwise it is ignored and flagged rejected
// rsp channel: exactly one result item per cmd item, in order, carrying the
// drive level for that tick, busy, done, presence and the last byte read
// configuration: write cfg_we/cfg_addr/cfg_data while idle; eight timing
// registers in ticks, data is LSB first
// path: a cmd item is registered in the input register, then the sequencer
// processes it into the output register, from which its result shows on rsp
// throughput: one item per cycle while rsp accepts results; the sequencer
// state updates once per item
// stall: while a result waits the sequencer holds, cmd.ready drops when
// the input register is full and not stepping; no item is lost or repeated
// reset: all timing registers return to their defaults, the sequencer is
// idle, presence and read byte are cleared, both stages are empty
module one_wire_bus_master #(
    parameter int unsigned TIMER_BITS = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    owbm_in_if.sink                           cmd,
    owbm_out_if.source                        rsp,
    input  logic                              cfg_we,
    input  logic [owbm_pkg::REG_IDX_W-1:0]    cfg_addr,
    input  logic [TIMER_BITS-1:0]             cfg_data
);

    logic                                          in_valid_reg;
    owbm_pkg::cmd_t                                in_data_reg;
    logic                                          out_valid_reg;
    owbm_pkg::result_t                             out_data_reg;
    logic                                          step;
    owbm_pkg::result_t                             res;
    logic [owbm_pkg::NUM_REGS-1:0][TIMER_BITS-1:0] cfg_regs;

    assign step      = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign cmd.ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ready)
            begin
                in_valid_reg <= cmd.valid;
            end
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            in_data_reg.func      <= cmd.func;
            in_data_reg.data_byte <= cmd.data_byte;
            in_data_reg.bus_level <= cmd.bus_level;
        end
        if (step)
        begin
            out_data_reg <= res;
        end
    end

    owbm_cfg #(
        .TIMER_BITS (TIMER_BITS)
    ) u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .addr  (cfg_addr),
        .data  (cfg_data),
        .regs  (cfg_regs)
    );

    owbm_seq #(
        .TIMER_BITS (TIMER_BITS)
    ) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .cmd   (in_data_reg),
        .cfg   (cfg_regs),
        .res   (res)
    );

    assign rsp.valid     = out_valid_reg;
    assign rsp.drive_low = out_data_reg.drive_low;
    assign rsp.busy_res  = out_data_reg.busy_res;
    assign rsp.done_res  = out_data_reg.done_res;
    assign rsp.presence  = out_data_reg.presence;
    assign rsp.read_data = out_data_reg.read_data;
    assign rsp.rejected  = out_data_reg.rejected;

endmodule
